// ===== rtl/bds_pkg.sv =====
// shared constants and types for the 2x2 box downscaler
package bds_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int MAX_COLS   = 2048;
	localparam int ROW_LIMIT  = 2048;
	localparam int LINE_DEPTH = MAX_COLS / 2;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int SIZE_W     = 12;
	localparam int CNT_W      = 11;
	localparam int PAIR_W     = PIXEL_BITS + 1;
	localparam int CFG_IDX_W  = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_ROWS = 1'b0,
		REG_IMAGE_COLS = 1'b1
	} cfg_reg_t;

	// control that travels with a word from the input stage to the average stage
	typedef struct packed {
		logic has_result;
		logic last;
		logic frame_wrap;
	} s1_ctrl_t;

endpackage

// ===== rtl/box_downscale_2x2.sv =====
// top level of the 2x2 box-filter downscaler
//
// input channel: one grayscale pixel word per accepted cycle (in_valid high,
// in_stall low), raster order, row-major, for a frame of image_rows by
// image_cols pixels. output channel: one averaged word per 2x2 block, with
// last_of_frame and frame_max on the frame's final block.
// configuration: cfg_we writes cfg_data into register cfg_index (0 = rows,
// 1 = cols); sizes are clamped to 2..2048, an odd trailing row or column is
// consumed but gives no output. write only while the block is idle.
// throughput: one pixel per clock while in_stall is low; the upper row's
// horizontal pair sums sit in a 1024-entry line memory with one write and one
// read port, and the lower row reads its entry once per pair, so the memory
// never limits the rate. output path: the lower right pixel's memory read and
// pair register feed the average stage, which loads the output reg (out_valid).
// reset: counters, left pixel and running max clear, sizes go to 2 by 2; the
// line memory is not cleared since every entry is written before it is read.
// receiver stall: the output register holds its word; the average stage then
// holds once it has a result word and in_stall rises, so no word is dropped.
module box_downscale_2x2
	import bds_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [15:0]           pixel_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [15:0]           avg_pixel,
	output logic                  last_of_frame,
	output logic [15:0]           frame_max
);

	// configuration registers
	logic [SIZE_W-1:0] image_rows_q;
	logic [SIZE_W-1:0] image_cols_q;

	// position and left pixel of the current pair
	logic [CNT_W-1:0]      row_q;
	logic [CNT_W-1:0]      col_q;
	logic [PIXEL_BITS-1:0] left_q;

	// average stage
	logic                  s1_valid_s1;
	s1_ctrl_t              ctrl_s1;
	logic [PAIR_W-1:0]     pair_s1;
	logic [PIXEL_BITS-1:0] run_max_q;

	// output register
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] avg_q;
	logic                  last_q;
	logic [PIXEL_BITS-1:0] fmax_q;

	// input stage signals
	logic                  accept;
	logic [SIZE_W-1:0]     rows;
	logic [SIZE_W-1:0]     cols;
	logic [SIZE_W-1:0]     rows_even;
	logic [SIZE_W-1:0]     cols_even;
	logic [SIZE_W-1:0]     r_ext;
	logic [SIZE_W-1:0]     c_ext;
	logic [PIXEL_BITS-1:0] pix;
	logic [PAIR_W-1:0]     pair;
	logic                  pair_col;
	logic                  mem_we;
	logic                  mem_re;
	logic [LINE_AW-1:0]    line_idx;
	logic [PAIR_W-1:0]     line_rdata;
	s1_ctrl_t              ctrl_in;
	logic                  col_wrap;
	logic                  row_wrap;

	// average stage signals
	logic                  s1_adv;
	logic                  s1_fire;
	logic [PAIR_W:0]       block_sum;
	logic [PIXEL_BITS-1:0] avg;
	logic [PIXEL_BITS-1:0] max_new;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= SIZE_W'(2);
			image_cols_q <= SIZE_W'(2);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_ROWS: image_rows_q <= cfg_data;
				REG_IMAGE_COLS: image_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp sizes to the supported range
	always_comb begin
		if (image_rows_q < SIZE_W'(2))
			rows = SIZE_W'(2);
		else if (image_rows_q > SIZE_W'(ROW_LIMIT))
			rows = SIZE_W'(ROW_LIMIT);
		else
			rows = image_rows_q;
		if (image_cols_q < SIZE_W'(2))
			cols = SIZE_W'(2);
		else if (image_cols_q > SIZE_W'(MAX_COLS))
			cols = SIZE_W'(MAX_COLS);
		else
			cols = image_cols_q;
	end

	// ---------------- input stage ----------------
	assign accept    = in_valid && !in_stall;
	assign rows_even = {rows[SIZE_W-1:1], 1'b0};
	assign cols_even = {cols[SIZE_W-1:1], 1'b0};
	assign r_ext     = SIZE_W'(row_q);
	assign c_ext     = SIZE_W'(col_q);
	assign pix       = pixel_value[PIXEL_BITS-1:0];
	assign pair      = PAIR_W'(left_q) + PAIR_W'(pix);
	assign line_idx  = col_q[LINE_AW:1];

	// odd column inside the even-width part of the row closes a pair
	assign pair_col = col_q[0] && (c_ext < cols_even);
	// upper row of a block pair: store the pair sum
	assign mem_we   = accept && pair_col && !row_q[0];
	// lower row: fetch the upper pair sum for this block
	assign mem_re   = accept && pair_col && row_q[0] && (r_ext < rows_even);

	assign col_wrap = c_ext >= (cols - SIZE_W'(1));
	assign row_wrap = r_ext >= (rows - SIZE_W'(1));

	always_comb begin
		ctrl_in.has_result = pair_col && row_q[0] && (r_ext < rows_even);
		ctrl_in.last       = (r_ext == rows_even - SIZE_W'(1))
			&& (c_ext == cols_even - SIZE_W'(1));
		ctrl_in.frame_wrap = col_wrap && row_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			if (!col_q[0]) begin
				left_q <= pix;
			end
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap)
					row_q <= '0;
				else
					row_q <= row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	bds_ram #(
		.DEPTH (LINE_DEPTH),
		.WIDTH (PAIR_W)
	) u_line (
		.clk   (clk),
		.we    (mem_we),
		.waddr (line_idx),
		.wdata (pair),
		.re    (mem_re),
		.raddr (line_idx),
		.rdata (line_rdata)
	);

	// ---------------- average stage ----------------
	// every accepted word passes here so frame-end clears stay in order
	assign s1_adv  = !s1_valid_s1 || !(ctrl_s1.has_result && out_valid_q && out_stall);
	assign s1_fire = s1_valid_s1 && s1_adv;
	assign in_stall = !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			ctrl_s1     <= '0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
			ctrl_s1     <= ctrl_in;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pair_s1 <= pair;
		end
	end

	assign block_sum = (PAIR_W+1)'(line_rdata) + (PAIR_W+1)'(pair_s1);
	assign avg       = block_sum[PAIR_W:2];
	assign max_new   = (avg > run_max_q) ? avg : run_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_max_q <= '0;
		end else if (s1_fire) begin
			if ((ctrl_s1.has_result && ctrl_s1.last) || ctrl_s1.frame_wrap)
				run_max_q <= '0;
			else if (ctrl_s1.has_result)
				run_max_q <= max_new;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && ctrl_s1.has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && ctrl_s1.has_result) begin
			avg_q  <= avg;
			last_q <= ctrl_s1.last;
			fmax_q <= ctrl_s1.last ? max_new : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign avg_pixel     = 16'(avg_q);
	assign last_of_frame = last_q;
	assign frame_max     = 16'(fmax_q);

	// ---------------- assertions ----------------
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked average stage");

	a_mem_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("line memory written and read by one word");

	a_max_covers_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (fmax_q >= avg_q))
		else $error("frame max below the last average");

	a_max_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (fmax_q == '0))
		else $error("frame max nonzero off the last word");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (s1_valid_s1 && ctrl_s1.has_result))
		else $error("memory read without a result in the average stage");

endmodule

// ===== rtl/bds_ram.sv =====
// simple dual-port line memory, one write and one registered read per cycle
module bds_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the 2x2 box downscaler with a behavioral predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bds_pkg::*;

	// timing of the run
	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_SLACK  = 8;         // margin for words still in the block
	localparam int END_SLACK    = 20;
	localparam int HOLD_CYCLES  = 300;       // long receiver hold-off
	localparam int RUN_LIMIT    = 1_000_000; // ns, far beyond the slowest correct run
	localparam int RANDOM_ITEMS = 500;

	// receiver stall patterns
	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HALF,
		RX_HEAVY
	} rx_mode_t;

	// one downscaled word as the block should present it
	typedef struct packed {
		logic [15:0] mean;
		logic        last;
		logic [15:0] peak;
	} mean_word_t;

	// dut ports, every input known from time zero
	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = REG_IMAGE_ROWS;
	logic [SIZE_W-1:0]    cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic [15:0]          pixel_value = '0;
	logic                 out_stall   = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic [15:0]          avg_pixel;
	logic                 last_of_frame;
	logic [15:0]          frame_max;

	// predictor state: configuration, raster position, line of upper pair sums
	logic [SIZE_W-1:0] rows_reg = SIZE_W'(2);
	logic [SIZE_W-1:0] cols_reg = SIZE_W'(2);
	int unsigned       row_pos  = 0;
	int unsigned       col_pos  = 0;
	logic [15:0]       left_pix = '0;
	logic [PAIR_W-1:0] upper_pairs [LINE_DEPTH];
	logic [15:0]       peak_mean = '0;

	// block means predicted but not yet seen on the output
	mean_word_t  pending_means [$];
	mean_word_t  want;
	int unsigned mismatch_count = 0;
	int unsigned pixels_taken   = 0;

	// sender bursts and receiver stall pattern
	int          burst_left    = 0;
	rx_mode_t    rx_mode       = RX_FREE;
	int          rx_phase_left = 0;
	int          hold_left     = 0;
	bit          hold_request  = 1'b0;

	box_downscale_2x2 u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel_value   (pixel_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.avg_pixel     (avg_pixel),
		.last_of_frame (last_of_frame),
		.frame_max     (frame_max)
	);

	always #HALF_PERIOD clk = ~clk;

	// sizes outside 2..hi behave as the nearest bound
	function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v, input int unsigned hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return 32'(v);
	endfunction

	// advance the predictor by one accepted pixel word
	task automatic fold_pixel(input logic [15:0] pix);
		int unsigned       rows;
		int unsigned       cols;
		int unsigned       rows_even;
		int unsigned       cols_even;
		int unsigned       r;
		int unsigned       c;
		int unsigned       idx;
		logic [PAIR_W-1:0] pair;
		logic [PAIR_W:0]   block_sum;
		mean_word_t        w;
		rows      = clamp_size(rows_reg, ROW_LIMIT);
		cols      = clamp_size(cols_reg, MAX_COLS);
		rows_even = rows - (rows % 2);
		cols_even = cols - (cols % 2);
		r = row_pos;
		c = col_pos;
		if (c % 2 == 0) begin
			left_pix = pix;
		end else if (c < cols_even) begin
			pair = PAIR_W'(left_pix) + PAIR_W'(pix);
			idx  = (c >> 1) % LINE_DEPTH;
			if (r % 2 == 0) begin
				// upper row of the block pair: remember the horizontal sum
				upper_pairs[idx] = pair;
			end else if (r < rows_even) begin
				block_sum = (PAIR_W+1)'(upper_pairs[idx]) + (PAIR_W+1)'(pair);
				w.mean    = block_sum[PAIR_W:2];
				w.last    = (r == rows_even - 1) && (c == cols_even - 1);
				if (w.mean > peak_mean) peak_mean = w.mean;
				w.peak = w.last ? peak_mean : 16'd0;
				if (w.last) peak_mean = '0;
				pending_means.push_back(w);
			end
		end
		// counters wrap on the bound in force now, even if it moved mid-frame
		if (c >= cols - 1) begin
			col_pos = 0;
			if (r >= rows - 1) begin
				row_pos   = 0;
				peak_mean = '0;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
		end
	endtask

	// pixel values weighted toward the range ends
	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: begin
				return 16'h0000;
			end
			1: begin
				return 16'hFFFF;
			end
			2: begin
				return 16'($urandom_range(16'hFF00, 16'hFFFF));
			end
			3: begin
				return 16'($urandom_range(0, 255));
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// offer one pixel word; bursts of random length with random gaps between them
	task automatic send_pixel(input logic [15:0] pix);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid    <= 1'b1;
		pixel_value <= pix;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		fold_pixel(pix);
		pixels_taken++;
		burst_left--;
	endtask

	// send pixels until the raster position is back at the start of a frame
	task automatic send_frame();
		do begin
			send_pixel(pick_pixel());
		end while (row_pos != 0 || col_pos != 0);
	endtask

	// stop offering and wait until every predicted word has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		// a trailing pixel with no word may still be in the pipe
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// both size registers, written only while the block is idle
	task automatic write_size(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
		cfg_we    <= 1'b1;
		cfg_index <= REG_IMAGE_ROWS;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_index <= REG_IMAGE_COLS;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_reg = rows;
		cols_reg = cols;
		@(posedge clk);
	endtask

	// reset size 2x2, all-ones and all-zero blocks, truncation of the mean
	task automatic test_reset_and_value_extremes();
		logic [15:0] seq [12] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0001, 16'h0002, 16'h0003};
		foreach (seq[i]) send_pixel(seq[i]);
		drain_results();
	endtask

	// odd trailing row and column are eaten without a word
	task automatic test_odd_trailing();
		logic [15:0] seq [9] = '{16'h8000, 16'h7FFF, 16'hFFFF,
			16'h0001, 16'hFFFE, 16'h1234,
			16'hFFFF, 16'h0000, 16'hAAAA};
		write_size(SIZE_W'(3), SIZE_W'(3));
		foreach (seq[i]) send_pixel(seq[i]);
		drain_results();
	endtask

	// sizes below two and above the limit
	task automatic test_size_clamp();
		logic [15:0] seq [4] = '{16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0};
		write_size(SIZE_W'(0), SIZE_W'(1));
		foreach (seq[i]) send_pixel(seq[i]);
		drain_results();
		write_size(SIZE_W'(1), SIZE_W'(0));
		send_frame();
		drain_results();
		// oversized frame: fill the start of an upper row, then narrow it
		write_size(12'hFFF, 12'hFFF);
		repeat (24) send_pixel(pick_pixel());
		drain_results();
		write_size(SIZE_W'(2), SIZE_W'(24));
		send_frame();
		drain_results();
	endtask

	// size moved in the middle of a frame, at an upper row so the line stays valid
	task automatic test_midframe_resize();
		repeat (3) begin
			write_size(SIZE_W'($urandom_range(2, 10)), SIZE_W'($urandom_range(2, 16)));
			repeat ($urandom_range(1, 60)) send_pixel(pick_pixel());
			while (row_pos % 2 != 0) send_pixel(pick_pixel());
			drain_results();
			write_size(SIZE_W'($urandom_range(0, 12)), SIZE_W'($urandom_range(0, 20)));
			// finish the broken frame, then one clean frame
			send_frame();
			send_frame();
			drain_results();
		end
	endtask

	// receiver holds off long enough that the block backs up into in_stall
	task automatic test_backpressure();
		write_size(SIZE_W'(4), SIZE_W'(16));
		hold_request = 1'b1;
		repeat (3) send_frame();
		// sender pauses until every word is out, then resumes
		drain_results();
		send_frame();
		drain_results();
	endtask

	// random whole frames, mostly small sizes with a few wide or tall ones
	task automatic test_random_frames();
		int unsigned start;
		int unsigned r;
		int unsigned c;
		start = pixels_taken;
		while (pixels_taken - start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					r = $urandom_range(2, 4);
					c = $urandom_range(32, 128);
				end
				1: begin
					r = $urandom_range(16, 64);
					c = $urandom_range(2, 4);
				end
				default: begin
					r = $urandom_range(2, 9);
					c = $urandom_range(2, 12);
				end
			endcase
			write_size(SIZE_W'(r), SIZE_W'(c));
			repeat ($urandom_range(1, 3)) send_frame();
			drain_results();
		end
	endtask

	// receiver: a long hold-off on request, otherwise phases of random stall density
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES - 1;
			out_stall   <= 1'b1;
		end else begin
			if (rx_phase_left == 0) begin
				rx_mode       = rx_mode_t'($urandom_range(0, 3));
				rx_phase_left = $urandom_range(10, 150);
			end
			rx_phase_left--;
			case (rx_mode)
				RX_FREE: begin
					out_stall <= 1'b0;
				end
				RX_LIGHT: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				RX_HALF: begin
					out_stall <= 1'($urandom_range(0, 1));
				end
				default: begin
					out_stall <= ($urandom_range(0, 3) != 0);
				end
			endcase
		end
	end

	// every accepted output word against the oldest prediction, field by field
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_means.size() == 0) begin
				report_mismatch($sformatf("word with none predicted: avg=%h last=%b max=%h",
					avg_pixel, last_of_frame, frame_max));
			end else begin
				want = pending_means.pop_front();
				if (avg_pixel !== want.mean)
					report_mismatch($sformatf("avg_pixel %h, want %h", avg_pixel, want.mean));
				if (last_of_frame !== want.last)
					report_mismatch($sformatf("last_of_frame %b, want %b", last_of_frame, want.last));
				if (frame_max !== want.peak)
					report_mismatch($sformatf("frame_max %h, want %h", frame_max, want.peak));
			end
		end
	end

	// overall limit on the run
	initial begin
		#RUN_LIMIT;
		$display("timeout at %0t, %0d words still pending", $time, pending_means.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		// reset once, released away from the rising edge
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_value_extremes();
		test_odd_trailing();
		test_size_clamp();
		test_midframe_resize();
		test_backpressure();
		test_random_frames();

		drain_results();
		repeat (END_SLACK) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
